[hdl/tpsa_pkg.sv]
// Shared types and constants for the target point steering angle unit.
package tpsa_pkg;

    localparam int ANGLE_ITERATIONS_DEF = 16;
    localparam int TABLE_LEN            = 24;

    // CORDIC datapath: |coord| (17 bits) << 20 plus growth and sign
    localparam int CORDIC_W = 38;
    // angle accumulator, degrees * 65536, signed
    localparam int ANGLE_W  = 25;
    localparam int TAB_W    = 22;

    localparam logic [22:0] DEG90_Q16 = 23'd5898240;
    localparam logic [17:0] DEG180_Q8 = 18'd46080;

    localparam logic [15:0] GAIN_RESET    = 16'd19661;
    localparam logic [15:0] HEADING_RESET = 16'd23040;
    localparam logic [14:0] MAX_RESET     = 15'd7168;

    // configuration register indexes
    localparam logic [1:0] REG_GAIN    = 2'd0;
    localparam logic [1:0] REG_HEADING = 2'd1;
    localparam logic [1:0] REG_MAX     = 2'd2;

    // atan(2^-i) in degrees * 65536
    localparam logic [TAB_W-1:0] ATAN_TAB [0:TABLE_LEN-1] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
        22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
        22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
    };

    // quadrant info that travels alongside the CORDIC vector
    typedef struct packed {
        logic x_neg;
        logic x_zero;
        logic y_neg;
        logic y_zero;
    } tag_t;

endpackage

[hdl/tpsa_cordic.sv]
// Pipelined vectoring CORDIC: one register stage per rotation.
module tpsa_cordic #(
    parameter int ITERATIONS = tpsa_pkg::ANGLE_ITERATIONS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  tpsa_pkg::tag_t                       in_tag,
    input  logic signed [tpsa_pkg::CORDIC_W-1:0] in_x,
    input  logic signed [tpsa_pkg::CORDIC_W-1:0] in_y,
    output logic                                 out_valid,
    output tpsa_pkg::tag_t                       out_tag,
    output logic signed [tpsa_pkg::ANGLE_W-1:0]  out_z
);

    localparam int CW = tpsa_pkg::CORDIC_W;
    localparam int ZW = tpsa_pkg::ANGLE_W;

    logic [ITERATIONS-1:0]  valid_reg;
    tpsa_pkg::tag_t         tag_reg [0:ITERATIONS-1];
    logic signed [CW-1:0]   x_reg   [0:ITERATIONS-1];
    logic signed [CW-1:0]   y_reg   [0:ITERATIONS-1];
    logic signed [ZW-1:0]   z_reg   [0:ITERATIONS-1];

    genvar i;
    generate
        for (i = 0; i < ITERATIONS; i++) begin : g_stage
            logic                 vi;
            tpsa_pkg::tag_t       ti;
            logic signed [CW-1:0] xi;
            logic signed [CW-1:0] yi;
            logic signed [ZW-1:0] zi;
            logic signed [CW-1:0] dx;
            logic signed [CW-1:0] dy;
            logic signed [ZW-1:0] step;
            logic                 rot_neg;

            if (i == 0) begin : g_first
                assign vi = in_valid;
                assign ti = in_tag;
                assign xi = in_x;
                assign yi = in_y;
                assign zi = '0;
            end else begin : g_next
                assign vi = valid_reg[i-1];
                assign ti = tag_reg[i-1];
                assign xi = x_reg[i-1];
                assign yi = y_reg[i-1];
                assign zi = z_reg[i-1];
            end

            // arithmetic shift is a floor shift
            assign dx      = yi >>> i;
            assign dy      = xi >>> i;
            assign step    = $signed({{(ZW-tpsa_pkg::TAB_W){1'b0}}, tpsa_pkg::ATAN_TAB[i]});
            assign rot_neg = yi[CW-1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[i] <= 1'b0;
                end
                else
                begin
                    valid_reg[i] <= vi;
                end
            end

            always_ff @(posedge clk)
            begin
                tag_reg[i] <= ti;
                if (!rot_neg)
                begin
                    x_reg[i] <= xi + dx;
                    y_reg[i] <= yi - dy;
                    z_reg[i] <= zi + step;
                end
                else
                begin
                    x_reg[i] <= xi - dx;
                    y_reg[i] <= yi + dy;
                    z_reg[i] <= zi - step;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[ITERATIONS-1];
    assign out_tag   = tag_reg[ITERATIONS-1];
    assign out_z     = z_reg[ITERATIONS-1];

    a_valid_through : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> ##ITERATIONS out_valid)
        else $error("cordic request lost in pipeline");

endmodule

[hdl/target_point_steering_angle_unit.sv]
// Top level: target point to clamped steering angle, fully pipelined.
// Pipeline: input stage, CORDIC stages (16 at the default ANGLE_ITERATIONS), angle rounding,
//   heading error, gain product and output registers; done is high with each result.
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// Reset: asynchronous, active low; clears all valid bits and loads the default gain,
//   heading and steering limit. Configuration writes are taken in any cycle.
module target_point_steering_angle_unit #(
    parameter int ANGLE_ITERATIONS = tpsa_pkg::ANGLE_ITERATIONS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] target_x,
    input  logic signed [15:0] target_y,
    output logic               done,
    output logic signed [15:0] steer_deg_q8,
    output logic               saturated,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int STAGES = (ANGLE_ITERATIONS > tpsa_pkg::TABLE_LEN) ?
                            tpsa_pkg::TABLE_LEN : ANGLE_ITERATIONS;
    localparam int LATENCY = STAGES + 5;
    localparam int CW = tpsa_pkg::CORDIC_W;
    localparam int ZW = tpsa_pkg::ANGLE_W;

    // configuration
    logic [15:0] gain_reg;
    logic [15:0] heading_reg;
    logic [14:0] max_reg;

    // input stage
    logic           s0_valid_reg;
    tpsa_pkg::tag_t s0_tag_reg;
    logic [16:0]    s0_ax_reg;
    logic [16:0]    s0_ay_reg;
    logic signed [16:0] x_ext;
    logic signed [16:0] y_ext;
    logic signed [CW-1:0] cordic_x;
    logic signed [CW-1:0] cordic_y;

    // CORDIC output
    logic                 cd_valid;
    tpsa_pkg::tag_t       cd_tag;
    logic signed [ZW-1:0] cd_z;

    // angle rounding stage
    logic           p1_valid_reg;
    tpsa_pkg::tag_t p1_tag_reg;
    logic [14:0]    p1_angle_reg;
    logic [14:0]    p1_angle_next;
    logic [22:0]    z_clamped;
    logic [23:0]    z_round;

    // heading error stage
    logic              p2_valid_reg;
    logic signed [17:0] p2_err_reg;
    logic signed [17:0] p2_err_next;
    logic signed [15:0] signed_angle;
    logic signed [17:0] bearing;

    // gain product stage
    logic               p3_valid_reg;
    logic signed [34:0] p3_prod_reg;

    // rounding and clamp
    logic        prod_neg;
    logic [34:0] prod_mag;
    logic [34:0] prod_round;
    logic [18:0] steer_mag;
    logic        steer_sat;
    logic [14:0] steer_lim;
    logic signed [15:0] steer_next;

    logic               done_reg;
    logic signed [15:0] steer_reg;
    logic               sat_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg    <= tpsa_pkg::GAIN_RESET;
            heading_reg <= tpsa_pkg::HEADING_RESET;
            max_reg     <= tpsa_pkg::MAX_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tpsa_pkg::REG_GAIN:    gain_reg    <= cfg_data;
                tpsa_pkg::REG_HEADING: heading_reg <= cfg_data;
                tpsa_pkg::REG_MAX:     max_reg     <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // ---- input stage: magnitudes and quadrant
    assign x_ext = 17'(target_x);
    assign y_ext = 17'(target_y);

    always_ff @(posedge clk)
    begin
        s0_ax_reg         <= target_x[15] ? 17'(-x_ext) : 17'(x_ext);
        s0_ay_reg         <= target_y[15] ? 17'(-y_ext) : 17'(y_ext);
        s0_tag_reg.x_neg  <= target_x[15];
        s0_tag_reg.x_zero <= (target_x == 16'sd0);
        s0_tag_reg.y_neg  <= target_y[15];
        s0_tag_reg.y_zero <= (target_y == 16'sd0);
    end

    // vector starts at (|y|, |x|) scaled by 2^20
    assign cordic_x = $signed({1'b0, s0_ay_reg, 20'b0});
    assign cordic_y = $signed({1'b0, s0_ax_reg, 20'b0});

    tpsa_cordic #(
        .ITERATIONS(STAGES)
    ) u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s0_valid_reg),
        .in_tag   (s0_tag_reg),
        .in_x     (cordic_x),
        .in_y     (cordic_y),
        .out_valid(cd_valid),
        .out_tag  (cd_tag),
        .out_z    (cd_z)
    );

    // ---- clamp to 0..90 degrees and round to degrees*256
    always_comb
    begin
        if (cd_z[ZW-1])
            z_clamped = '0;
        else if (cd_z > $signed({{(ZW-23){1'b0}}, tpsa_pkg::DEG90_Q16}))
            z_clamped = tpsa_pkg::DEG90_Q16;
        else
            z_clamped = cd_z[22:0];
        z_round = {1'b0, z_clamped} + 24'd128;
        // zero forward or lateral offset gives zero atan
        if (cd_tag.x_zero || cd_tag.y_zero)
            p1_angle_next = '0;
        else
            p1_angle_next = z_round[22:8];
    end

    always_ff @(posedge clk)
    begin
        p1_tag_reg   <= cd_tag;
        p1_angle_reg <= p1_angle_next;
    end

    // ---- bearing and heading error
    always_comb
    begin
        signed_angle = p1_tag_reg.x_neg ? -$signed({1'b0, p1_angle_reg})
                                        :  $signed({1'b0, p1_angle_reg});
        if (p1_tag_reg.y_zero)
            bearing = '0;
        else if (p1_tag_reg.y_neg)
            bearing = 18'(signed_angle);
        else
            bearing = $signed(tpsa_pkg::DEG180_Q8) - 18'(signed_angle);
        p2_err_next = bearing - $signed({2'b0, heading_reg});
    end

    always_ff @(posedge clk)
    begin
        p2_err_reg <= p2_err_next;
    end

    // ---- gain product
    always_ff @(posedge clk)
    begin
        p3_prod_reg <= p2_err_reg * $signed({1'b0, gain_reg});
    end

    // ---- round half away from zero, then clamp
    always_comb
    begin
        prod_neg   = p3_prod_reg[34];
        prod_mag   = prod_neg ? 35'(-p3_prod_reg) : 35'(p3_prod_reg);
        prod_round = prod_mag + 35'd32768;
        steer_mag  = prod_round[34:16];
        steer_sat  = steer_mag > {4'b0, max_reg};
        steer_lim  = steer_sat ? max_reg : steer_mag[14:0];
        steer_next = prod_neg ? -$signed({1'b0, steer_lim}) : $signed({1'b0, steer_lim});
    end

    always_ff @(posedge clk)
    begin
        steer_reg <= steer_next;
        sat_reg   <= steer_sat;
    end

    // ---- valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= start && !busy;
            p1_valid_reg <= cd_valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            done_reg     <= p3_valid_reg;
        end
    end

    assign done         = done_reg;
    assign steer_deg_q8 = steer_reg;
    assign saturated    = sat_reg;

    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("request did not produce a result at the expected latency");

    a_within_limit : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (steer_deg_q8 <= $signed({1'b0, max_reg}))
              && (steer_deg_q8 >= -$signed({1'b0, max_reg})))
        else $error("steering angle outside limit");

    a_sat_at_limit : assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |-> (steer_deg_q8 == $signed({1'b0, max_reg}))
                             || (steer_deg_q8 == -$signed({1'b0, max_reg})))
        else $error("saturated result not at the limit");

endmodule
